[hdl/pdfm_pkg.sv]
package pdfm_pkg;

  localparam int CntWidthDef = 16;  // default width of the running totals
  localparam int CntWMax     = 32;  // widest totals the snapshot word carries
  localparam int TsW         = 16;
  localparam int ClkHzW      = 26;
  localparam int SkipW       = 7;
  localparam int SkipCntW    = 8;
  localparam int DutyW       = 10;
  localparam int FreqW       = 16;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = ClkHzW;
  localparam int QueueDepth  = 2;

  localparam logic [DutyW-1:0]  DutyScale   = 10'd1000;
  localparam logic [FreqW-1:0]  FreqLimit   = 16'hFFFF;
  localparam logic [ClkHzW-1:0] ClkHzReset  = 26'd16000000;
  localparam logic [SkipW-1:0]  SkipMaxReset = 7'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgClkHz   = 1'b0,
    CfgSkipMax = 1'b1
  } cfg_idx_e;

  // totals taken at an update command, handed from front to back
  typedef struct packed {
    logic                absent;
    logic [CntWMax-1:0]  period_total;
    logic [CntWMax-1:0]  high_total;
    logic [CntWMax-1:0]  cycle_count;
    logic [ClkHzW-1:0]   clk_hz;
  } snap_t;

endpackage

[hdl/pdfm_front.sv]
module pdfm_front import pdfm_pkg::*; #(
  parameter int CounterWidth = CntWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                cmd_i,
  input  logic                edge_rising_i,
  input  logic [TsW-1:0]      timestamp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output snap_t               q_wdata_o
);

  logic [ClkHzW-1:0]       clk_hz_q;
  logic [SkipW-1:0]        skip_max_q;
  logic [CounterWidth-1:0] fall_q, fall_d;
  logic [CounterWidth-1:0] rise_q, rise_d;
  logic [CounterWidth-1:0] ptot_q, ptot_d;
  logic [CounterWidth-1:0] htot_q, htot_d;
  logic [CounterWidth-1:0] cyc_q, cyc_d;
  logic [SkipCntW-1:0]     skip_q, skip_d;
  logic                    pend_q, pend_d;
  logic                    rsel_q, rsel_d;

  logic                    accept;
  logic [CounterWidth-1:0] ts;
  logic [CounterWidth-1:0] period;
  logic [CounterWidth-1:0] low;
  logic [SkipCntW-1:0]     skip_dec;
  logic                    skipping;

  assign accept   = push_i && !q_full_i;
  assign ts       = CounterWidth'(timestamp_i);
  assign period   = ts - rise_q;
  assign low      = rise_q - fall_q;
  assign skip_dec = skip_q - SkipCntW'(1);
  // signed count still above zero: edge is only counted
  assign skipping = (skip_dec != '0) && !skip_dec[SkipCntW-1];

  always_comb begin
    fall_d = fall_q;
    rise_d = rise_q;
    ptot_d = ptot_q;
    htot_d = htot_q;
    cyc_d  = cyc_q;
    skip_d = skip_q;
    pend_d = pend_q;
    rsel_d = rsel_q;
    if (accept && cmd_i) begin
      ptot_d = '0;
      htot_d = '0;
      cyc_d  = '0;
    end else if (accept && (edge_rising_i == rsel_q)) begin
      skip_d = skip_dec;
      if (!skipping) begin
        if (!rsel_q) begin
          fall_d = ts;
          pend_d = 1'b0;
          rsel_d = 1'b1;
        end else if (!pend_q) begin
          rise_d = ts;
          pend_d = 1'b1;
        end else begin
          ptot_d = ptot_q + period;
          htot_d = htot_q + period - low;
          cyc_d  = cyc_q + CounterWidth'(1);
          skip_d = SkipCntW'(skip_max_q);
          rsel_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q   <= ClkHzReset;
      skip_max_q <= SkipMaxReset;
      fall_q     <= '0;
      rise_q     <= '0;
      ptot_q     <= '0;
      htot_q     <= '0;
      cyc_q      <= '0;
      skip_q     <= SkipCntW'(SkipMaxReset);
      pend_q     <= 1'b0;
      rsel_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgClkHz:   clk_hz_q   <= cfg_wdata_i[ClkHzW-1:0];
          CfgSkipMax: skip_max_q <= cfg_wdata_i[SkipW-1:0];
          default: ;
        endcase
      end
      fall_q <= fall_d;
      rise_q <= rise_d;
      ptot_q <= ptot_d;
      htot_q <= htot_d;
      cyc_q  <= cyc_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      rsel_q <= rsel_d;
    end
  end

  assign q_push_o               = accept && cmd_i;
  assign q_wdata_o.absent       = (ptot_q == '0);
  assign q_wdata_o.period_total = CntWMax'(ptot_q);
  assign q_wdata_o.high_total   = CntWMax'(htot_q);
  assign q_wdata_o.cycle_count  = CntWMax'(cyc_q);
  assign q_wdata_o.clk_hz       = clk_hz_q;

endmodule

[hdl/pdfm_queue.sv]
module pdfm_queue import pdfm_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  snap_t wdata_i,
  input  logic  pop_i,
  output snap_t rdata_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  snap_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[hdl/pdfm_back.sv]
module pdfm_back import pdfm_pkg::*; #(
  parameter int CounterWidth = CntWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  snap_t            q_rdata_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DutyW-1:0] duty_permille_o,
  output logic [FreqW-1:0] frequency_hz_o,
  output logic             signal_absent_o
);

  localparam int DutyDvdW = CounterWidth + DutyW;
  localparam int DvdW     = CounterWidth + ClkHzW;
  localparam int StepW    = $clog2(DvdW + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DUTY = 5'b00100,
    S_FREQ = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [CounterWidth-1:0] period_q;
  logic [CounterWidth-1:0] high_q;
  logic [CounterWidth-1:0] cyc_q;
  logic [ClkHzW-1:0]       clk_hz_q;
  logic                    absent_q;
  logic [DvdW-1:0]         prodf_q;
  logic [DvdW-1:0]         dvd_q;
  logic [DvdW-1:0]         quo_q;
  logic [CounterWidth-1:0] rem_q;
  logic [StepW-1:0]        step_q;
  logic [DutyW-1:0]        duty_q;
  logic [FreqW-1:0]        freq_q;
  logic                    out_valid_q;
  logic [DutyW-1:0]        out_duty_q;
  logic [FreqW-1:0]        out_freq_q;
  logic                    out_absent_q;

  logic [DutyDvdW-1:0]     prod_duty;
  logic [DvdW-1:0]         prod_freq;
  logic [CounterWidth:0]   rem_sh;
  logic [CounterWidth:0]   rem_diff;
  logic                    qbit;
  logic [DvdW-1:0]         quo_next;
  logic [CounterWidth-1:0] rem_next;
  logic                    last_step;
  logic                    out_load;

  assign prod_duty = DutyDvdW'(high_q) * DutyDvdW'(DutyScale);
  assign prod_freq = DvdW'(clk_hz_q) * DvdW'(cyc_q);

  // restoring divider, one quotient bit per cycle
  assign rem_sh    = {rem_q, dvd_q[DvdW-1]};
  assign rem_diff  = rem_sh - {1'b0, period_q};
  assign qbit      = (rem_sh >= {1'b0, period_q});
  assign rem_next  = qbit ? rem_diff[CounterWidth-1:0] : rem_sh[CounterWidth-1:0];
  assign quo_next  = {quo_q[DvdW-2:0], qbit};
  assign last_step = (step_q == StepW'(1));

  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!q_empty_i) state_d = q_rdata_i.absent ? S_DONE : S_MUL;
      S_MUL:  state_d = S_DUTY;
      S_DUTY: if (last_step) state_d = S_FREQ;
      S_FREQ: if (last_step) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        period_q <= q_rdata_i.period_total[CounterWidth-1:0];
        high_q   <= q_rdata_i.high_total[CounterWidth-1:0];
        cyc_q    <= q_rdata_i.cycle_count[CounterWidth-1:0];
        clk_hz_q <= q_rdata_i.clk_hz;
        absent_q <= q_rdata_i.absent;
        duty_q   <= '0;
        freq_q   <= '0;
      end
      S_MUL: begin
        // duty dividend is top-aligned so it runs fewer steps
        dvd_q   <= {prod_duty, {(DvdW - DutyDvdW){1'b0}}};
        prodf_q <= prod_freq;
        quo_q   <= '0;
        rem_q   <= '0;
        step_q  <= StepW'(DutyDvdW);
      end
      S_DUTY: begin
        if (last_step) begin
          duty_q <= (quo_next > DvdW'(DutyScale)) ? DutyScale : quo_next[DutyW-1:0];
          dvd_q  <= prodf_q;
          quo_q  <= '0;
          rem_q  <= '0;
          step_q <= StepW'(DvdW);
        end else begin
          dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
          quo_q  <= quo_next;
          rem_q  <= rem_next;
          step_q <= step_q - StepW'(1);
        end
      end
      S_FREQ: begin
        if (last_step) begin
          freq_q <= (quo_next > DvdW'(FreqLimit)) ? FreqLimit : quo_next[FreqW-1:0];
        end
        dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
        quo_q  <= quo_next;
        rem_q  <= rem_next;
        step_q <= step_q - StepW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_duty_q   <= duty_q;
      out_freq_q   <= freq_q;
      out_absent_q <= absent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o         = !out_valid_q;
  assign duty_permille_o = out_duty_q;
  assign frequency_hz_o  = out_freq_q;
  assign signal_absent_o = out_absent_q;

`ifndef SYNTHESIS
  a_no_div_by_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUTY || state_q == S_FREQ) |-> (period_q != '0))
    else $error("divider running with zero period total");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUTY || state_q == S_FREQ) |-> (step_q != '0))
    else $error("divider step count ran out");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_freq_q)
                                 && $stable(out_duty_q)))
    else $error("waiting result overwritten");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && absent_q) |-> (duty_q == '0 && freq_q == '0))
    else $error("absent signal reported nonzero result");
`endif

endmodule

[hdl/pwm_duty_frequency_meter_core.sv]
// Edge words: accepted one per cycle while the queue is not full, no result word.
// Update words: one result word each; the shared bit-serial divider runs duty
// (COUNTER_WIDTH+10 steps) then frequency (COUNTER_WIDTH+26), and is skipped when
// the signal is absent. The divider works on one update at a time.
// Up to two updates queue ahead of the divider; one result word is buffered.
// rst_ni clears totals, captures and queues; registers return to defaults.
module pwm_duty_frequency_meter_core import pdfm_pkg::*; #(
  parameter int COUNTER_WIDTH = CntWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                cmd_i,
  input  logic                edge_rising_i,
  input  logic [TsW-1:0]      timestamp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [DutyW-1:0]    duty_permille_o,
  output logic [FreqW-1:0]    frequency_hz_o,
  output logic                signal_absent_o
);

  logic  q_push, q_pop, q_full, q_empty;
  snap_t q_wdata, q_rdata;

  pdfm_front #(
    .CounterWidth(COUNTER_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .cmd_i        (cmd_i),
    .edge_rising_i(edge_rising_i),
    .timestamp_i  (timestamp_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata)
  );

  pdfm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pdfm_back #(
    .CounterWidth(COUNTER_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_rdata_i      (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .duty_permille_o(duty_permille_o),
    .frequency_hz_o (frequency_hz_o),
    .signal_absent_o(signal_absent_o)
  );

  assign full_o = q_full;

endmodule
